[rtl/core/wgip_pkg.sv]
// Package with the types, constants and codes shared by the weighted group item picker.
`timescale 1ns / 1ps
`default_nettype none
package wgip_pkg;

  localparam int GROUP_COUNT       = 14;
  localparam int CENTER_GROUP      = 0;
  localparam int ENTRIES_PER_GROUP = 16;

  localparam int STORE_DEPTH = GROUP_COUNT * ENTRIES_PER_GROUP;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GRP_W       = 4;
  localparam int CNT_W       = $clog2(ENTRIES_PER_GROUP + 1);
  localparam int TOT_W       = 16 + CNT_W;
  localparam int DRAW_W      = TOT_W + 1;
  localparam int SCAN_W      = $clog2(GROUP_COUNT + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_PICK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  // Sources for the current group register.
  localparam logic [1:0] SRC_REQ    = 2'd0;
  localparam logic [1:0] SRC_CENTER = 2'd1;
  localparam logic [1:0] SRC_SCAN   = 2'd2;

  // Search phases of a pick.
  localparam logic [1:0] PH_REQ    = 2'd0;
  localparam logic [1:0] PH_CENTER = 2'd1;
  localparam logic [1:0] PH_SCAN   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  group_index;
    logic [15:0] item_code;
    logic [15:0] weight;
    logic [31:0] random_word;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] picked_code;
    logic [1:0]  status;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MOD_START,
    S_MOD_RUN,
    S_READ,
    S_WALK,
    S_NEXT,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic do_add;
    logic do_clear;
    logic sel_group;      // load the current group register
    logic [1:0] grp_src;  // requested, centre or scan counter
    logic scan_inc;
    logic mod_start;
    logic mod_step;
    logic walk_start;
    logic walk_step;
    logic set_result;
    logic [1:0] res_status;
    logic take_pick;      // copy walk result into picked code
    logic load_out;       // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] operation;
    logic add_ok;          // requested group in range and not full
    logic req_ok;          // requested group in range and its total weight nonzero
    logic center_ok;       // centre fallback permitted and centre total weight nonzero
    logic cur_ok;          // current group has entries and nonzero total weight
    logic scan_done;
    logic mod_done;
    logic walk_done;
    logic walk_hit;
    logic walk_nonzero;
  } stat_t;

endpackage
`default_nettype wire

[rtl/core/wgip_datapath.sv]
// Datapath of the picker: group tables, entry memory, serial modulo and weight walk.
`timescale 1ns / 1ps
`default_nettype none
module wgip_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wgip_pkg::in_beat_t     in_data,
  input  wgip_pkg::cmd_t         cmd,
  output wgip_pkg::stat_t        stat,
  output wgip_pkg::out_beat_t    res
);

  localparam int NG = wgip_pkg::GROUP_COUNT;
  localparam int NE = wgip_pkg::ENTRIES_PER_GROUP;

  logic [31:0] mem [wgip_pkg::STORE_DEPTH];
  logic [31:0] rd_r;

  logic [wgip_pkg::CNT_W-1:0] cnt_r [NG];
  logic [wgip_pkg::TOT_W-1:0] tot_r [NG];

  wgip_pkg::in_beat_t in_r;
  logic [wgip_pkg::GRP_W-1:0]  grp_r;
  logic [wgip_pkg::SCAN_W-1:0] scan_r;
  logic [wgip_pkg::TOT_W-1:0]  rem_r, cur_tot;
  logic [31:0]                 quo_r;
  logic [5:0]                  bit_r;
  logic [wgip_pkg::DRAW_W-1:0] draw_r;
  logic [wgip_pkg::CNT_W-1:0]  k_r, cur_cnt;
  logic                        hit_r;
  logic [15:0]                 hit_id_r;
  wgip_pkg::out_beat_t         res_r;
  wgip_pkg::out_beat_t         res_out_r;

  logic req_in;
  logic add_ok;
  logic [wgip_pkg::ADDR_W-1:0] rd_addr, wr_addr;

  assign req_in  = ({1'b0, in_r.group_index} < (wgip_pkg::GRP_W+1)'(NG));
  assign add_ok  = req_in && (cnt_r[in_r.group_index] < wgip_pkg::CNT_W'(NE));
  assign cur_tot = tot_r[grp_r];
  assign cur_cnt = cnt_r[grp_r];
  assign rd_addr = wgip_pkg::ADDR_W'(grp_r * NE) + wgip_pkg::ADDR_W'(k_r);
  assign wr_addr = wgip_pkg::ADDR_W'(in_r.group_index * NE)
                 + wgip_pkg::ADDR_W'(cnt_r[in_r.group_index]);

  always_ff @(posedge clk) begin
    if (cmd.do_add && add_ok) begin
      mem[wr_addr] <= {in_r.weight, in_r.item_code};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NG; i++) begin
        cnt_r[i] <= '0;
        tot_r[i] <= '0;
      end
    end else if (cmd.do_clear) begin
      for (int i = 0; i < NG; i++) begin
        cnt_r[i] <= '0;
        tot_r[i] <= '0;
      end
    end else if (cmd.do_add && add_ok) begin
      cnt_r[in_r.group_index] <= cnt_r[in_r.group_index] + 1'b1;
      tot_r[in_r.group_index] <= tot_r[in_r.group_index]
                                 + wgip_pkg::TOT_W'(in_r.weight);
    end
  end

  logic [wgip_pkg::TOT_W:0] rem_sh;
  assign rem_sh = {rem_r, quo_r[31]};

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.sel_group) begin
      case (cmd.grp_src)
        wgip_pkg::SRC_REQ:    grp_r <= in_r.group_index;
        wgip_pkg::SRC_CENTER: grp_r <= wgip_pkg::GRP_W'(wgip_pkg::CENTER_GROUP);
        default:              grp_r <= wgip_pkg::GRP_W'(scan_r);
      endcase
    end
    if (cmd.load_in) scan_r <= '0;
    else if (cmd.scan_inc) scan_r <= scan_r + 1'b1;
    // Restoring remainder, one dividend bit a cycle.
    if (cmd.mod_start) begin
      rem_r <= '0;
      quo_r <= in_r.random_word;
      bit_r <= '0;
    end else if (cmd.mod_step) begin
      quo_r <= {quo_r[30:0], 1'b0};
      bit_r <= bit_r + 1'b1;
      if (rem_sh >= {1'b0, cur_tot}) rem_r <= wgip_pkg::TOT_W'(rem_sh - {1'b0, cur_tot});
      else rem_r <= rem_sh[wgip_pkg::TOT_W-1:0];
    end
    if (cmd.walk_start) begin
      draw_r <= wgip_pkg::DRAW_W'(rem_r) + 1'b1;
      k_r    <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.walk_step && !hit_r) begin
      if (draw_r <= wgip_pkg::DRAW_W'(rd_r[31:16])) begin
        hit_r    <= 1'b1;
        hit_id_r <= rd_r[15:0];
      end else begin
        draw_r <= draw_r - wgip_pkg::DRAW_W'(rd_r[31:16]);
        k_r    <= k_r + 1'b1;
      end
    end
    if (cmd.walk_start) hit_id_r <= '0;
    if (cmd.load_in) res_r <= '0;
    else if (cmd.take_pick) res_r.picked_code <= hit_id_r;
    if (cmd.set_result) res_r.status <= cmd.res_status;
    if (cmd.load_out) res_out_r <= res_r;
  end

  always_comb begin
    stat.operation    = in_r.operation;
    stat.add_ok       = add_ok;
    stat.req_ok       = req_in && (tot_r[in_r.group_index[wgip_pkg::GRP_W-1:0]] != '0);
    stat.center_ok    = (in_r.group_index != wgip_pkg::GRP_W'(wgip_pkg::CENTER_GROUP))
                      && (wgip_pkg::CENTER_GROUP < NG)
                      && (tot_r[wgip_pkg::CENTER_GROUP % NG] != '0);
    stat.cur_ok       = (cur_tot != '0) && (cur_cnt != '0);
    stat.scan_done    = (scan_r == wgip_pkg::SCAN_W'(NG));
    stat.mod_done     = (bit_r == 6'd32);
    stat.walk_done    = hit_r || (k_r >= cur_cnt);
    stat.walk_hit     = hit_r;
    stat.walk_nonzero = hit_r && (hit_id_r != '0);
  end

  assign res = res_out_r;

endmodule
`default_nettype wire

[rtl/core/wgip_ctrl.sv]
// Controller state machine sequencing add, clear and the pick search.
`timescale 1ns / 1ps
`default_nettype none
module wgip_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wgip_pkg::stat_t     stat,
  output wgip_pkg::cmd_t      cmd
);

  wgip_pkg::state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;  // requested, centre or scan
  logic out_valid_r, out_valid_nxt;
  logic step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wgip_pkg::S_IDLE;
      phase_r     <= wgip_pkg::PH_REQ;
      out_valid_r <= 1'b0;
      step_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      wgip_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = wgip_pkg::S_DECIDE;
        end
      end
      wgip_pkg::S_DECIDE: begin
        case (stat.operation)
          wgip_pkg::OP_ADD: begin
            cmd.do_add = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_status = stat.add_ok ? wgip_pkg::ST_DONE : wgip_pkg::ST_IGNORED;
            state_nxt = wgip_pkg::S_RESULT;
            phase_nxt = wgip_pkg::PH_REQ;
          end
          wgip_pkg::OP_PICK: begin
            cmd.sel_group = 1'b1;
            if (stat.req_ok) begin
              cmd.grp_src = wgip_pkg::SRC_REQ;
              phase_nxt   = wgip_pkg::PH_REQ;
              state_nxt   = wgip_pkg::S_MOD_START;
            end else if (stat.center_ok) begin
              cmd.grp_src = wgip_pkg::SRC_CENTER;
              phase_nxt   = wgip_pkg::PH_CENTER;
              state_nxt   = wgip_pkg::S_MOD_START;
            end else begin
              cmd.grp_src = wgip_pkg::SRC_SCAN;
              phase_nxt   = wgip_pkg::PH_SCAN;
              state_nxt   = wgip_pkg::S_NEXT;
            end
          end
          wgip_pkg::OP_CLEAR: begin
            cmd.do_clear = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_status = wgip_pkg::ST_DONE;
            state_nxt = wgip_pkg::S_RESULT;
            phase_nxt = wgip_pkg::PH_REQ;
          end
          default: begin
            cmd.set_result = 1'b1;
            cmd.res_status = wgip_pkg::ST_DONE;
            state_nxt = wgip_pkg::S_RESULT;
            phase_nxt = wgip_pkg::PH_REQ;
          end
        endcase
      end
      wgip_pkg::S_NEXT: begin
        // Scan phase: group register already holds the scan counter value.
        if (stat.scan_done) begin
          cmd.set_result = 1'b1;
          cmd.res_status = wgip_pkg::ST_NONE;
          state_nxt = wgip_pkg::S_RESULT;
        end else if (stat.cur_ok) begin
          state_nxt = wgip_pkg::S_MOD_START;
        end else begin
          cmd.scan_inc  = 1'b1;
          state_nxt     = wgip_pkg::S_READ;
        end
      end
      wgip_pkg::S_READ: begin
        // Reload the group register from the scan counter.
        cmd.sel_group = 1'b1;
        cmd.grp_src   = wgip_pkg::SRC_SCAN;
        state_nxt     = wgip_pkg::S_NEXT;
      end
      wgip_pkg::S_MOD_START: begin
        cmd.mod_start = 1'b1;
        state_nxt     = wgip_pkg::S_MOD_RUN;
      end
      wgip_pkg::S_MOD_RUN: begin
        if (stat.mod_done) begin
          cmd.walk_start = 1'b1;
          step_nxt       = 1'b0;
          state_nxt      = wgip_pkg::S_WALK;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      wgip_pkg::S_WALK: begin
        // Memory read data is registered behind the entry index, so a toggle gates each step.
        if (stat.walk_done) begin
          if (phase_r == wgip_pkg::PH_REQ || stat.walk_nonzero) begin
            cmd.take_pick  = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_status = stat.walk_nonzero ? wgip_pkg::ST_DONE : wgip_pkg::ST_NONE;
            state_nxt = wgip_pkg::S_RESULT;
          end else begin
            cmd.sel_group = 1'b1;
            cmd.grp_src   = wgip_pkg::SRC_SCAN;
            if (phase_r == wgip_pkg::PH_SCAN) cmd.scan_inc = 1'b1;
            phase_nxt = wgip_pkg::PH_SCAN;
            state_nxt = wgip_pkg::S_READ;
          end
        end else begin
          cmd.walk_step = step_r;
          step_nxt      = !step_r;
        end
      end
      wgip_pkg::S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = wgip_pkg::S_IDLE;
        end
      end
      default: state_nxt = wgip_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/weighted_group_item_picker_unit.sv]
// Top level of the weighted group item picker: controller and datapath joined.
`timescale 1ns / 1ps
`default_nettype none
// Takes one beat at a time. Add, clear and unused operations pass from acceptance through
// the decide state to the result register. A pick runs the serial 32-bit modulo of the
// random word by the group total and then walks the stored entries on the entry memory,
// with a toggle gating each step so the registered read data can follow, and this repeats
// for each fallback group searched, passing through a next and a read state for each
// group stepped over in the scan. The result beat is held in an output register while
// the next beat is taken.
module weighted_group_item_picker_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wgip_pkg::in_beat_t       in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wgip_pkg::out_beat_t      out_data
);

  wgip_pkg::cmd_t  cmd;
  wgip_pkg::stat_t stat;

  wgip_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  wgip_datapath u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .res(out_data)
  );

endmodule
`default_nettype wire

[tb/tb_weighted_group_item_picker_unit.sv]
// Self-checking testbench for the weighted group item picker: random and directed beats.
`timescale 1ns / 1ps
module tb_weighted_group_item_picker_unit;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wgip_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wgip_pkg::out_beat_t out_data;

  weighted_group_item_picker_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the group tables.
  logic [15:0] grp_code [wgip_pkg::GROUP_COUNT][wgip_pkg::ENTRIES_PER_GROUP];
  logic [15:0] grp_wt [wgip_pkg::GROUP_COUNT][wgip_pkg::ENTRIES_PER_GROUP];
  int unsigned grp_cnt [wgip_pkg::GROUP_COUNT];
  int unsigned grp_sum [wgip_pkg::GROUP_COUNT];

  wgip_pkg::in_beat_t pending_beats[$];
  wgip_pkg::out_beat_t expected_results[$];
  int errors = 0;
  int picks_done = 0;
  int picks_empty = 0;
  int adds_full = 0;
  bit stim_done = 1'b0;

  function automatic void queue_beat(wgip_pkg::in_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic logic [15:0] draw_from(int g, logic [31:0] rnd);
    int unsigned d;
    if (grp_sum[g] == 0) return 16'd0;
    d = (rnd % grp_sum[g]) + 1;
    for (int k = 0; k < grp_cnt[g]; k++) begin
      if (d <= grp_wt[g][k]) return grp_code[g][k];
      d -= grp_wt[g][k];
    end
    return 16'd0;
  endfunction

  function automatic logic [15:0] roulette_pick(int g, logic [31:0] rnd);
    logic [15:0] id;
    if (g < wgip_pkg::GROUP_COUNT && grp_sum[g] > 0) return draw_from(g, rnd);
    if (g != wgip_pkg::CENTER_GROUP && wgip_pkg::CENTER_GROUP < wgip_pkg::GROUP_COUNT) begin
      id = draw_from(wgip_pkg::CENTER_GROUP, rnd);
      if (id != 0) return id;
    end
    for (int k = 0; k < wgip_pkg::GROUP_COUNT; k++) begin
      id = draw_from(k, rnd);
      if (id != 0) return id;
    end
    return 16'd0;
  endfunction

  task automatic predict_beat(wgip_pkg::in_beat_t b);
    wgip_pkg::out_beat_t r;
    int g;
    r = '0;
    g = b.group_index;
    case (b.operation)
      wgip_pkg::OP_ADD: begin
        if (g >= wgip_pkg::GROUP_COUNT || grp_cnt[g] >= wgip_pkg::ENTRIES_PER_GROUP) begin
          r.status = wgip_pkg::ST_IGNORED;
          adds_full++;
        end else begin
          grp_code[g][grp_cnt[g]] = b.item_code;
          grp_wt[g][grp_cnt[g]] = b.weight;
          grp_cnt[g]++;
          grp_sum[g] += b.weight;
        end
      end
      wgip_pkg::OP_PICK: begin
        r.picked_code = roulette_pick(g, b.random_word);
        r.status = (r.picked_code == 0) ? wgip_pkg::ST_NONE : wgip_pkg::ST_DONE;
        picks_done++;
        if (r.picked_code == 0) picks_empty++;
      end
      wgip_pkg::OP_CLEAR: begin
        for (int k = 0; k < wgip_pkg::GROUP_COUNT; k++) begin
          grp_cnt[k] = 0;
          grp_sum[k] = 0;
        end
      end
      default: ;
    endcase
    expected_results.insert(expected_results.size(), r);
  endtask

  function automatic wgip_pkg::in_beat_t make_beat(logic [1:0] op, logic [3:0] g,
                                                   logic [15:0] code, logic [15:0] w,
                                                   logic [31:0] rnd);
    wgip_pkg::in_beat_t b;
    b.operation = op;
    b.group_index = g;
    b.item_code = code;
    b.weight = w;
    b.random_word = rnd;
    return b;
  endfunction

  // Driver: waits a random gap, then presents the next beat until it is taken.
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      predict_beat(in_data);
      in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (in_gap == 0 && pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor and receiver stall.
  int out_wait = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data);
          errors++;
        end else begin
          wgip_pkg::out_beat_t e;
          e = expected_results.pop_front();
          if (e.picked_code !== out_data.picked_code) begin
            $display("%0t: picked_code expected %h actual %h", $time, e.picked_code,
                     out_data.picked_code);
            errors++;
          end
          if (e.status !== out_data.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_data.status);
            errors++;
          end
        end
        out_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        out_stall <= (out_wait > 0);
      end else if (out_wait > 0) begin
        out_wait--;
        out_stall <= (out_wait > 0);
      end
    end
  end

  initial begin
    logic [1:0] op;
    logic [3:0] g;
    int sel;
    for (int k = 0; k < wgip_pkg::GROUP_COUNT; k++) begin
      grp_cnt[k] = 0;
      grp_sum[k] = 0;
    end
    // Directed: empty picks, extremes, zero weights, full group, out of range, clear.
    queue_beat(make_beat(wgip_pkg::OP_PICK, 4'd3, 16'h0, 16'h0, 32'h0));
    queue_beat(make_beat(wgip_pkg::OP_ADD, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
    queue_beat(make_beat(wgip_pkg::OP_ADD, 4'd5, 16'hAAAA, 16'h0, 32'h0));
    queue_beat(make_beat(wgip_pkg::OP_PICK, 4'd5, 16'h0, 16'h0, 32'h12345678));
    queue_beat(make_beat(wgip_pkg::OP_ADD, 4'd5, 16'h0, 16'h0003, 32'h0));
    queue_beat(make_beat(wgip_pkg::OP_PICK, 4'd5, 16'h0, 16'h0, 32'h1));
    queue_beat(make_beat(wgip_pkg::OP_ADD, 4'd13, 16'hFFFF, 16'hFFFF, 32'h0));
    queue_beat(make_beat(wgip_pkg::OP_PICK, 4'd14, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
    queue_beat(make_beat(wgip_pkg::OP_ADD, 4'd0, 16'h5555, 16'h0001, 32'h0));
    queue_beat(make_beat(wgip_pkg::OP_PICK, 4'd7, 16'h0, 16'h0, 32'hFFFFFFFF));
    for (int k = 0; k < 17; k++)
      queue_beat(make_beat(wgip_pkg::OP_ADD, 4'd2, 16'(k + 1), 16'hFFFF, 32'h0));
    queue_beat(make_beat(wgip_pkg::OP_PICK, 4'd2, 16'h0, 16'h0, 32'hFFFFFFFF));
    queue_beat(make_beat(wgip_pkg::OP_UNUSED, 4'd2, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
    queue_beat(make_beat(wgip_pkg::OP_CLEAR, 4'd0, 16'h0, 16'h0, 32'h0));
    queue_beat(make_beat(wgip_pkg::OP_PICK, 4'd2, 16'h0, 16'h0, 32'h0));
    // Random: mostly adds and picks over a few groups, occasional clears.
    for (int n = 0; n < 500; n++) begin
      sel = $urandom_range(0, 99);
      op = (sel < 50) ? wgip_pkg::OP_ADD : (sel < 95) ? wgip_pkg::OP_PICK :
           (sel < 98) ? wgip_pkg::OP_CLEAR : wgip_pkg::OP_UNUSED;
      g = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
      queue_beat(make_beat(op, g, 16'($urandom),
          ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom), $urandom));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
    $display("Covered %0d picks (%0d found nothing) and %0d ignored adds.",
             picks_done, picks_empty, adds_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout.");
    $display("Mismatches found");
    $finish;
  end
endmodule
